// ----- rtl/mmm_pkg.sv -----
// mmm_pkg: shared constants, beat structs and route register layout for the
// modulation matrix mixer. No dependencies; used by every file under rtl.
`timescale 1ns / 1ps
`default_nettype none

package mmm_pkg;

   // sizing of the matrix
   localparam int ROUTE_SLOTS  = 8;
   localparam int DEST_COUNT   = 15;
   localparam int SOURCE_COUNT = 7;
   localparam int REG_COUNT    = 8;
   localparam int REG_IDX_W    = $clog2(REG_COUNT);
   localparam int CSR_INDEX_W  = REG_IDX_W + 1;
   localparam int CSR_DATA_W   = 24;

   localparam int LEVEL_W = 16;
   localparam int SRC_W   = 3;
   localparam int DEST_W  = 4;
   localparam int TERM_W  = 17;
   localparam int SUM_W   = 20;

   // source codes
   localparam logic [SRC_W-1:0] SRC_NONE       = 3'd0;
   localparam logic [SRC_W-1:0] SRC_LFO_ONE    = 3'd1;
   localparam logic [SRC_W-1:0] SRC_LFO_TWO    = 3'd2;
   localparam logic [SRC_W-1:0] SRC_FILTER_ENV = 3'd3;
   localparam logic [SRC_W-1:0] SRC_AMP_ENV    = 3'd4;
   localparam logic [SRC_W-1:0] SRC_VELOCITY   = 3'd5;
   localparam logic [SRC_W-1:0] SRC_WHEEL      = 3'd6;
   localparam logic [SRC_W-1:0] SRC_LIMIT      = SRC_W'(SOURCE_COUNT);

   // destination codes
   localparam logic [DEST_W-1:0] DEST_NONE  = 4'd0;
   localparam logic [DEST_W-1:0] DEST_FIRST = 4'd1;
   localparam logic [DEST_W-1:0] DEST_LAST  = DEST_W'(DEST_COUNT - 1);
   localparam logic [DEST_W:0]   DEST_LIMIT = (DEST_W + 1)'(DEST_COUNT);

   typedef struct packed {
      logic signed [LEVEL_W-1:0] lfo_one_level;
      logic signed [LEVEL_W-1:0] lfo_two_level;
      logic signed [LEVEL_W-1:0] filter_env_level;
      logic signed [LEVEL_W-1:0] amp_env_level;
      logic signed [LEVEL_W-1:0] velocity_level;
      logic signed [LEVEL_W-1:0] wheel_level;
   } req_beat_type;

   typedef struct packed {
      logic [DEST_W-1:0]       dest_index;
      logic signed [SUM_W-1:0] mod_sum;
      logic                    last;
   } rsp_beat_type;

   typedef struct packed {
      logic                      enable;
      logic [SRC_W-1:0]          source;
      logic [DEST_W-1:0]         dest;
      logic signed [LEVEL_W-1:0] amount;
   } route_type;

   // one lane's contribution; dest is DEST_NONE when the route is skipped
   typedef struct packed {
      logic [DEST_W-1:0]        dest;
      logic signed [TERM_W-1:0] term;
   } lane_term_type;

endpackage

`default_nettype wire

// ----- rtl/mmm_lane.sv -----
// mmm_lane: one routing slot. Picks the source level, scales it by the route
// amount and registers the floored Q2.15 product. Depends on mmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmm_lane (
   input  wire logic                  clock,
   input  wire logic                  load,
   input  wire mmm_pkg::req_beat_type levels,
   input  wire mmm_pkg::route_type    route,
   output mmm_pkg::lane_term_type     lane_term
);
   import mmm_pkg::*;

   logic signed [LEVEL_W-1:0]   level;
   logic signed [2*LEVEL_W-1:0] prod;
   logic                        active;
   lane_term_type               term_ff;
   lane_term_type               term_in;

   always_comb begin
      case (route.source)
         SRC_LFO_ONE:    level = levels.lfo_one_level;
         SRC_LFO_TWO:    level = levels.lfo_two_level;
         SRC_FILTER_ENV: level = levels.filter_env_level;
         SRC_AMP_ENV:    level = levels.amp_env_level;
         SRC_VELOCITY:   level = levels.velocity_level;
         SRC_WHEEL:      level = levels.wheel_level;
         default:        level = '0;
      endcase
   end

   assign prod = level * route.amount;

   assign active = route.enable
                   && (route.source != SRC_NONE)
                   && ({1'b0, route.source} < {1'b0, SRC_LIMIT})
                   && (route.dest != DEST_NONE)
                   && ({1'b0, route.dest} < DEST_LIMIT);

   always_comb begin
      // upper bits of the product are the arithmetic shift by 15, which floors
      term_in.term = prod[2*LEVEL_W-1:LEVEL_W-1];
      term_in.dest = active ? route.dest : DEST_NONE;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         term_ff <= term_in;
      end
   end

   assign lane_term = term_ff;

endmodule

`default_nettype wire

// ----- rtl/mmm_merge.sv -----
// mmm_merge: captures the lane terms of one beat and walks the destinations,
// summing the matching terms into the registered result beat.
// Depends on mmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmm_merge (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   lane_valid,
   output logic                        lane_take,
   input  wire mmm_pkg::lane_term_type lane_terms [mmm_pkg::ROUTE_SLOTS],
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output mmm_pkg::rsp_beat_type       rsp_data
);
   import mmm_pkg::*;

   logic              busy_ff, busy_in;
   logic [DEST_W-1:0] dest_ff, dest_in;
   lane_term_type     terms_ff [ROUTE_SLOTS];
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_beat_type      rsp_data_ff, rsp_data_in;
   logic              emit;
   logic              last_dest;
   logic signed [SUM_W-1:0] sum;

   assign emit      = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign last_dest = (dest_ff == DEST_LAST);
   // a new beat can be captured while the last destination goes out
   assign lane_take = lane_valid && (!busy_ff || (emit && last_dest));

   always_comb begin
      sum = '0;
      for (int i = 0; i < ROUTE_SLOTS; i++) begin
         if (terms_ff[i].dest == dest_ff) begin
            sum = sum + {{(SUM_W-TERM_W){terms_ff[i].term[TERM_W-1]}}, terms_ff[i].term};
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      dest_in = dest_ff;
      if (emit) begin
         if (last_dest) begin
            busy_in = 1'b0;
         end else begin
            dest_in = dest_ff + DEST_W'(1);
         end
      end
      if (lane_take) begin
         busy_in = 1'b1;
         dest_in = DEST_FIRST;
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      rsp_data_in.dest_index = dest_ff;
      rsp_data_in.mod_sum    = sum;
      rsp_data_in.last       = last_dest;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         dest_ff      <= DEST_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         dest_ff      <= dest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (lane_take) begin
         terms_ff <= lane_terms;
      end
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_last_on_final_dest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.last == (rsp_data_ff.dest_index == DEST_LAST)))
      else $error("last mark does not match final destination");

   a_take_restarts: assert property (@(posedge clock) disable iff (reset)
      lane_take |=> (busy_ff && dest_ff == DEST_FIRST))
      else $error("captured beat did not restart the destination walk");

   a_dest_steps: assert property (@(posedge clock) disable iff (reset)
      (emit && !last_dest) |=> (dest_ff == $past(dest_ff) + DEST_W'(1)))
      else $error("destination walk skipped or repeated");

   a_dest_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (dest_ff != DEST_NONE && {1'b0, dest_ff} < DEST_LIMIT))
      else $error("destination counter out of range");

endmodule

`default_nettype wire

// ----- rtl/modulation_matrix_mixer_core.sv -----
// modulation_matrix_mixer_core: top level with route registers, lane bank
// and merge stage. Depends on mmm_pkg, mmm_lane and mmm_merge.
//
//   channel | direction | handshake             | beat
//   req     | in        | req_valid / req_ready | req_beat_type, six source levels
//   rsp     | out       | rsp_valid / rsp_ready | rsp_beat_type, one destination
//   csr     | in        | csr_valid / csr_ready | csr_index, csr_wdata (route word)
//
// each req beat yields DEST_COUNT-1 rsp beats (14), one per cycle unless rsp stalls,
// out of the single result register, behind the lane and merge term registers.
// the lane stage holds the next beat while the merge stage walks destinations,
// so it is taken as the last destination goes out, with no gaps on rsp.
// synchronous reset clears all routes (disabled) and empties both stages.
// rsp stalls hold the result register; req_ready drops once the lane stage fills.
`timescale 1ns / 1ps
`default_nettype none

module modulation_matrix_mixer_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire mmm_pkg::req_beat_type                req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output mmm_pkg::rsp_beat_type                     rsp_data,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [mmm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [mmm_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import mmm_pkg::*;

   route_type     route_ff [REG_COUNT];
   logic          lane_valid_ff, lane_valid_in;
   logic          lane_take;
   logic          req_accept;
   lane_term_type lane_terms [ROUTE_SLOTS];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            route_ff[i] <= '0;
         end
      end else if (csr_valid && (csr_index < CSR_INDEX_W'(REG_COUNT))) begin
         route_ff[csr_index[REG_IDX_W-1:0]] <= route_type'(csr_wdata);
      end
   end

   assign req_ready  = !lane_valid_ff || lane_take;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      if (req_accept) begin
         lane_valid_in = 1'b1;
      end else if (lane_take) begin
         lane_valid_in = 1'b0;
      end else begin
         lane_valid_in = lane_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_valid_ff <= 1'b0;
      end else begin
         lane_valid_ff <= lane_valid_in;
      end
   end

   for (genvar g = 0; g < ROUTE_SLOTS; g++) begin : g_lane
      mmm_lane u_lane (
         .clock     (clock),
         .load      (req_accept),
         .levels    (req_data),
         .route     (route_ff[g]),
         .lane_term (lane_terms[g])
      );
   end

   mmm_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .lane_valid (lane_valid_ff),
      .lane_take  (lane_take),
      .lane_terms (lane_terms),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ----- sim/modulation_matrix_mixer_core_tb.sv -----
// modulation_matrix_mixer_core_tb: self-checking bench for the modulation matrix mixer.
// Drives route writes and source-level beats, and predicts the 14 destination sums of
// each beat. Depends on mmm_pkg and modulation_matrix_mixer_core.
`timescale 1ns / 1ps

module modulation_matrix_mixer_core_tb;
   import mmm_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 21;
   localparam int HOLD_CYCLES  = 150;
   localparam logic signed [LEVEL_W-1:0] AMT_MAX = 16'sh7FFF;
   localparam logic signed [LEVEL_W-1:0] AMT_MIN = 16'sh8000;
   localparam logic signed [LEVEL_W-1:0] LVL_MAX = 16'sh7FFF;
   localparam logic signed [LEVEL_W-1:0] LVL_MIN = 16'sh8000;
   localparam logic [CSR_INDEX_W-1:0] IDX_PAST = CSR_INDEX_W'(REG_COUNT);
   localparam logic [CSR_INDEX_W-1:0] IDX_TOP  = '1;
   localparam logic [DEST_W-1:0] DEST_OUT = DEST_W'(DEST_LIMIT);

   typedef enum {ROW_CSR, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type              kind;
      logic [CSR_INDEX_W-1:0]    index;
      route_type                 word;
      req_beat_type              beat;
      bit                        known;
      logic [DEST_W-1:0]         hot_dest;
      int                        hot_sum;
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_beat_type           req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_beat_type           rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   route_type      route_shadow [REG_COUNT];
   rsp_beat_type   mix_expect_q [$];
   stim_row_type   directed_rows [$];
   rsp_beat_type   want_beat;
   int             fail_count = 0;
   int             cycle_count = 0;
   int             rsp_hold_cycles = 0;
   bit             req_idle_on = 1'b1;
   bit             rsp_idle_on = 1'b1;

   modulation_matrix_mixer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic int source_level(input req_beat_type beat, input logic [SRC_W-1:0] code);
      case (code)
         SRC_LFO_ONE:    return int'($signed(beat.lfo_one_level));
         SRC_LFO_TWO:    return int'($signed(beat.lfo_two_level));
         SRC_FILTER_ENV: return int'($signed(beat.filter_env_level));
         SRC_AMP_ENV:    return int'($signed(beat.amp_env_level));
         SRC_VELOCITY:   return int'($signed(beat.velocity_level));
         SRC_WHEEL:      return int'($signed(beat.wheel_level));
         default:        return 0;
      endcase
   endfunction

   // one beat per destination, ascending, last mark on the final one
   function automatic void predict_mix(input req_beat_type beat);
      int           dest_sum [16];
      route_type    r;
      rsp_beat_type b;
      foreach (dest_sum[d]) dest_sum[d] = 0;
      for (int s = 0; s < ROUTE_SLOTS; s++) begin
         r = route_shadow[s];
         if (!r.enable) continue;
         if (r.source == SRC_NONE || r.source >= SRC_LIMIT) continue;
         if (r.dest == DEST_NONE || r.dest >= DEST_LIMIT) continue;
         // arithmetic shift floors toward minus infinity
         dest_sum[r.dest] += (source_level(beat, r.source) * int'(r.amount)) >>> 15;
      end
      for (int d = 1; d < DEST_COUNT; d++) begin
         b.dest_index = DEST_W'(d);
         b.mod_sum    = SUM_W'(dest_sum[d]);
         b.last       = (d == DEST_COUNT - 1);
         mix_expect_q.push_back(b);
      end
   endfunction

   // hand-written expectation: every destination zero except hot_dest
   function automatic void push_known(input logic [DEST_W-1:0] hot_dest, input int hot_sum);
      rsp_beat_type b;
      for (int d = 1; d < DEST_COUNT; d++) begin
         b.dest_index = DEST_W'(d);
         b.mod_sum    = (DEST_W'(d) == hot_dest) ? SUM_W'(hot_sum) : '0;
         b.last       = (d == DEST_COUNT - 1);
         mix_expect_q.push_back(b);
      end
   endfunction

   function automatic route_type make_route(input bit en, input logic [SRC_W-1:0] src,
                                            input logic [DEST_W-1:0] dst,
                                            input logic signed [LEVEL_W-1:0] amt);
      route_type r;
      r.enable = en;
      r.source = src;
      r.dest   = dst;
      r.amount = amt;
      return r;
   endfunction

   function automatic req_beat_type levels(input logic [LEVEL_W-1:0] a, b, c, d, e, f);
      req_beat_type beat;
      beat.lfo_one_level    = a;
      beat.lfo_two_level    = b;
      beat.filter_env_level = c;
      beat.amp_env_level    = d;
      beat.velocity_level   = e;
      beat.wheel_level      = f;
      return beat;
   endfunction

   function automatic logic [LEVEL_W-1:0] rand_level();
      int pick;
      pick = $urandom_range(0, 15);
      if (pick < 2) return LVL_MIN;
      if (pick < 4) return LVL_MAX;
      if (pick == 4) return '0;
      return LEVEL_W'($urandom);
   endfunction

   function automatic route_type rand_route(input int phase);
      route_type r;
      r = route_type'(CSR_DATA_W'($urandom));
      case (phase)
         0: r.enable = 1'b0;
         1: r = make_route(1'b1, SRC_W'($urandom_range(1, 6)), DEST_LAST, AMT_MIN);
         2: r = make_route(1'b1, SRC_W'($urandom_range(1, 6)), DEST_FIRST, AMT_MAX);
         default: begin
            // mostly live routes, the rest raw words with any codes
            if ($urandom_range(0, 3) != 0) begin
               r.enable = 1'b1;
               r.source = SRC_W'($urandom_range(1, 6));
               r.dest   = DEST_W'($urandom_range(1, 14));
            end
            case ($urandom_range(0, 7))
               0: r.amount = AMT_MAX;
               1: r.amount = AMT_MIN;
               default: ;
            endcase
         end
      endcase
      return r;
   endfunction

   function automatic void add_csr(input logic [CSR_INDEX_W-1:0] idx, input route_type word);
      stim_row_type row;
      row.kind     = ROW_CSR;
      row.index    = idx;
      row.word     = word;
      row.beat     = '0;
      row.known    = 1'b0;
      row.hot_dest = DEST_NONE;
      row.hot_sum  = 0;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_item(input req_beat_type beat, input bit known,
                                    input logic [DEST_W-1:0] hot_dest, input int hot_sum);
      stim_row_type row;
      row.kind     = ROW_ITEM;
      row.index    = '0;
      row.word     = '0;
      row.beat     = beat;
      row.known    = known;
      row.hot_dest = hot_dest;
      row.hot_sum  = hot_sum;
      directed_rows.push_back(row);
   endfunction

   task automatic wait_drained();
      while (mix_expect_q.size() != 0) @(posedge clock);
   endtask

   // leaves csr_valid high; the caller drops it after the last write of a group
   task automatic write_route(input logic [CSR_INDEX_W-1:0] idx, input route_type word);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= word;
      do @(posedge clock); while (!csr_ready);
      if (idx < REG_COUNT) route_shadow[idx] = word;
   endtask

   task automatic send_item(input req_beat_type beat, input bit known,
                            input logic [DEST_W-1:0] hot_dest, input int hot_sum);
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      if (known) push_known(hot_dest, hot_sum);
      else predict_mix(beat);
   endtask

   // response side: random stall bursts, one long hold-off on request
   initial begin
      int n;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            n = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if (rsp_idle_on && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (mix_expect_q.size() == 0) begin
            $display("%0t unexpected beat: expected none, actual dest %0d sum %0d last %0d",
                     $time, rsp_data.dest_index, rsp_data.mod_sum, rsp_data.last);
            fail_count++;
         end else begin
            want_beat = mix_expect_q.pop_front();
            if (rsp_data.dest_index !== want_beat.dest_index) begin
               $display("%0t dest_index mismatch: expected %0d actual %0d",
                        $time, want_beat.dest_index, rsp_data.dest_index);
               fail_count++;
            end
            if (rsp_data.mod_sum !== want_beat.mod_sum) begin
               $display("%0t mod_sum mismatch (dest %0d): expected %0d actual %0d",
                        $time, want_beat.dest_index, want_beat.mod_sum, rsp_data.mod_sum);
               fail_count++;
            end
            if (rsp_data.last !== want_beat.last) begin
               $display("%0t last mismatch (dest %0d): expected %0d actual %0d",
                        $time, want_beat.dest_index, want_beat.last, rsp_data.last);
               fail_count++;
            end
         end
      end
   end

   initial begin
      stim_row_type row;
      req_beat_type beat;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      foreach (route_shadow[i]) route_shadow[i] = '0;

      // routes are all off out of reset
      add_item(levels(LVL_MIN, LVL_MIN, LVL_MIN, LVL_MIN, LVL_MIN, LVL_MIN), 1, DEST_NONE, 0);
      add_item(levels(LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX), 1, DEST_NONE, 0);
      // full-scale products
      add_csr(0, make_route(1'b1, SRC_LFO_ONE, DEST_FIRST, AMT_MAX));
      add_item(levels(LVL_MIN, LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX), 1, DEST_FIRST,
               -32767);
      add_item(levels(LVL_MAX, LVL_MIN, LVL_MIN, LVL_MIN, LVL_MIN, LVL_MIN), 1, DEST_FIRST,
               32766);
      add_csr(0, make_route(1'b1, SRC_LFO_ONE, DEST_FIRST, AMT_MIN));
      add_item(levels(LVL_MIN, LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX), 1, DEST_FIRST,
               32768);
      add_item(levels(LVL_MAX, LVL_MIN, LVL_MIN, LVL_MIN, LVL_MIN, LVL_MIN), 1, DEST_FIRST,
               -32767);
      // skipped routes: disabled, no source, source past the inputs, no dest, dest past range
      add_csr(0, make_route(1'b0, SRC_LFO_ONE, DEST_FIRST, AMT_MIN));
      add_item(levels(LVL_MIN, LVL_MIN, LVL_MIN, LVL_MIN, LVL_MIN, LVL_MIN), 1, DEST_NONE, 0);
      add_csr(0, make_route(1'b1, SRC_NONE, DEST_FIRST, AMT_MIN));
      add_item(levels(LVL_MIN, LVL_MIN, LVL_MIN, LVL_MIN, LVL_MIN, LVL_MIN), 1, DEST_NONE, 0);
      add_csr(0, make_route(1'b1, SRC_LIMIT, DEST_FIRST, AMT_MIN));
      add_item(levels(LVL_MIN, LVL_MIN, LVL_MIN, LVL_MIN, LVL_MIN, LVL_MIN), 1, DEST_NONE, 0);
      add_csr(0, make_route(1'b1, SRC_LFO_ONE, DEST_NONE, AMT_MIN));
      add_item(levels(LVL_MIN, LVL_MIN, LVL_MIN, LVL_MIN, LVL_MIN, LVL_MIN), 1, DEST_NONE, 0);
      add_csr(0, make_route(1'b1, SRC_LFO_ONE, DEST_OUT, AMT_MIN));
      add_item(levels(LVL_MIN, LVL_MIN, LVL_MIN, LVL_MIN, LVL_MIN, LVL_MIN), 1, DEST_NONE, 0);
      // writes past the register file must not land anywhere
      add_csr(IDX_PAST, make_route(1'b1, SRC_LFO_ONE, DEST_FIRST, AMT_MIN));
      add_csr(IDX_TOP, make_route(1'b1, SRC_LFO_ONE, DEST_FIRST, AMT_MIN));
      add_item(levels(LVL_MIN, LVL_MIN, LVL_MIN, LVL_MIN, LVL_MIN, LVL_MIN), 1, DEST_NONE, 0);
      // every source, two routes sharing the last destination
      add_csr(0, make_route(1'b1, SRC_LFO_ONE, DEST_W'(1), 16'sh4000));
      add_csr(1, make_route(1'b1, SRC_LFO_TWO, DEST_W'(3), -16'sh1234));
      add_csr(2, make_route(1'b1, SRC_FILTER_ENV, DEST_W'(5), AMT_MAX));
      add_csr(3, make_route(1'b1, SRC_AMP_ENV, DEST_W'(7), AMT_MIN));
      add_csr(4, make_route(1'b1, SRC_VELOCITY, DEST_W'(9), 16'sh0001));
      add_csr(5, make_route(1'b1, SRC_WHEEL, DEST_W'(11), -16'sh0001));
      add_csr(6, make_route(1'b1, SRC_WHEEL, DEST_LAST, AMT_MIN));
      add_csr(7, make_route(1'b1, SRC_FILTER_ENV, DEST_LAST, 16'sh2AAA));
      add_item(levels(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA), 0,
               DEST_NONE, 0);
      add_item(levels(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555), 0,
               DEST_NONE, 0);
      add_item(levels(LVL_MIN, LVL_MIN, LVL_MIN, LVL_MIN, LVL_MIN, LVL_MIN), 0, DEST_NONE, 0);
      add_item(levels(LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX), 0, DEST_NONE, 0);
      add_item(levels(16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF), 0,
               DEST_NONE, 0);
      // widest sums: all eight slots into one destination
      for (int i = 0; i < REG_COUNT; i++)
         add_csr(CSR_INDEX_W'(i), make_route(1'b1, SRC_LFO_ONE, DEST_LAST, AMT_MIN));
      add_item(levels(LVL_MIN, 0, 0, 0, 0, 0), 1, DEST_LAST, 262144);
      add_item(levels(LVL_MAX, 0, 0, 0, 0, 0), 1, DEST_LAST, -262136);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         if (row.kind == ROW_CSR) begin
            req_valid <= 1'b0;
            wait_drained();
            write_route(row.index, row.word);
         end else begin
            csr_valid <= 1'b0;
            send_item(row.beat, row.known, row.hot_dest, row.hot_sum);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         req_valid <= 1'b0;
         wait_drained();
         for (int i = 0; i < REG_COUNT; i++)
            write_route(CSR_INDEX_W'(i), rand_route(p));
         write_route(CSR_INDEX_W'($urandom_range(REG_COUNT, 15)),
                     route_type'(CSR_DATA_W'($urandom)));
         csr_valid <= 1'b0;
         req_idle_on = (p != 3) && (p < 8);
         rsp_idle_on = (p < 8);
         // receiver holds off while the sender keeps pushing, so req_ready must drop
         if (p == 3) rsp_hold_cycles = HOLD_CYCLES;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            beat = levels(rand_level(), rand_level(), rand_level(), rand_level(),
                          rand_level(), rand_level());
            send_item(beat, 1'b0, DEST_NONE, 0);
         end
      end
      req_valid <= 1'b0;

      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
